### sv/chunked_credential_reassembler_core_macros.svh
// Assertion macros for the credential reassembler.
`ifndef CHUNKED_CREDENTIAL_REASSEMBLER_CORE_MACROS_SVH
`define CHUNKED_CREDENTIAL_REASSEMBLER_CORE_MACROS_SVH

// Check a consequence in the cycle after its trigger.
`define CCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reassembler check failed: next-cycle property");

// Check a consequence in the same cycle as its trigger.
`define CCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reassembler check failed: same-cycle property");

`endif

### sv/ccr_pkg.sv
// Shared constants and types for the credential reassembler.
package ccr_pkg;

    localparam int NAME_MAX    = 32;
    localparam int SECRET_MAX  = 63;
    localparam int CHUNK_BYTES = 6;

    localparam int CNT_W  = 6;
    localparam int SUM_W  = CNT_W + 1;
    localparam int N_W    = 3;

    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_NAME   = 3'd1;
    localparam logic [2:0] ACT_SECRET = 3'd2;
    localparam logic [2:0] ACT_END    = 3'd3;

    localparam logic [3:0] HDR_BYTES = 4'd2;

    typedef struct packed {
        logic             take;
        logic [N_W-1:0]   n;
        logic [CNT_W-1:0] count;
    } chunk_t;

endpackage

### sv/ccr_count.sv
// Chunk byte count, clamping and store-overflow check for one string.
module ccr_count (
    input  logic [3:0]               frame_length,
    input  logic [7:0]               expected,
    input  logic [ccr_pkg::CNT_W-1:0] have,
    input  logic [ccr_pkg::SUM_W-1:0] cap,
    output ccr_pkg::chunk_t          chunk
);
    import ccr_pkg::*;

    logic [3:0]       n_raw;
    logic [N_W-1:0]   n_clamp;
    logic [7:0]       left;
    logic [N_W-1:0]   n_final;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        n_raw   = (frame_length < HDR_BYTES) ? 4'd0 : frame_length - HDR_BYTES;
        n_clamp = (n_raw > 4'(CHUNK_BYTES)) ? N_W'(CHUNK_BYTES) : n_raw[N_W-1:0];
        left    = (expected > {2'b00, have}) ? expected - {2'b00, have} : 8'd0;
        n_final = ({5'b00000, n_clamp} > left) ? left[N_W-1:0] : n_clamp;
        sum     = {1'b0, have} + {{(SUM_W-N_W){1'b0}}, n_final};
        chunk.take  = (sum <= cap);
        chunk.n     = n_final;
        chunk.count = sum[CNT_W-1:0];
    end

endmodule

### sv/ccr_lane.sv
// One payload byte lane: pass the byte when it falls inside the chunk.
module ccr_lane (
    input  logic [7:0]              data,
    input  logic [ccr_pkg::N_W-1:0] lane_index,
    input  logic [ccr_pkg::N_W-1:0] n,
    input  logic                    enable,
    output logic [7:0]              masked
);
    import ccr_pkg::*;

    assign masked = (enable && (lane_index < n)) ? data : 8'd0;

endmodule

### sv/ccr_merge.sv
// Merge of the lane bytes into the running XOR.
module ccr_merge (
    input  logic [7:0] xor_in,
    input  logic [7:0] lane_bytes [ccr_pkg::CHUNK_BYTES],
    output logic [7:0] xor_out
);
    import ccr_pkg::*;

    always_comb
    begin
        xor_out = xor_in;
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            xor_out = xor_out ^ lane_bytes[i];
        end
    end

endmodule

### sv/chunked_credential_reassembler_core.sv
// Top level of the chunked credential reassembler.
//
// Takes one bus frame per cycle and updates the counts and running XOR in the
// same cycle, the six payload bytes handled by parallel lanes merged by one XOR
// stage; an end frame while armed yields one status transaction in the next cycle
// from the result register. Frames that produce no result are never stalled;
// an end frame stalls only while a previous result is still held downstream.
`include "chunked_credential_reassembler_core_macros.svh"

module chunked_credential_reassembler_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      frame_valid,
    output logic                      frame_stall,
    input  logic [2:0]                action,
    input  logic [3:0]                frame_length,
    input  logic [7:0]                data_byte_1,
    input  logic [7:0]                data_byte_2,
    input  logic [7:0]                data_byte_3,
    input  logic [7:0]                data_byte_4,
    input  logic [7:0]                data_byte_5,
    input  logic [7:0]                data_byte_6,
    input  logic [7:0]                data_byte_7,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic                      accepted,
    output logic                      checksum_ok,
    output logic [ccr_pkg::CNT_W-1:0] name_count,
    output logic [ccr_pkg::CNT_W-1:0] secret_count
);
    import ccr_pkg::*;

    logic             armed_reg;
    logic [7:0]       name_expected_reg;
    logic [7:0]       secret_expected_reg;
    logic [CNT_W-1:0] name_received_reg;
    logic [CNT_W-1:0] secret_received_reg;
    logic [7:0]       running_xor_reg;
    logic             result_valid_reg;
    logic             accepted_reg;
    logic             checksum_ok_reg;
    logic [CNT_W-1:0] name_count_reg;
    logic [CNT_W-1:0] secret_count_reg;

    logic             frame_fire;
    logic             result_fire;
    logic             is_end;
    logic             is_chunk;
    logic             end_hit;
    logic             ck;
    chunk_t           name_chunk;
    chunk_t           secret_chunk;
    chunk_t           sel_chunk;
    logic             lane_enable;
    logic [7:0]       payload    [CHUNK_BYTES];
    logic [7:0]       lane_bytes [CHUNK_BYTES];
    logic [7:0]       xor_next;

    assign is_end      = (action == ACT_END);
    assign is_chunk    = action inside {ACT_NAME, ACT_SECRET};
    assign frame_stall = result_valid_reg && result_stall && is_end && armed_reg;
    assign frame_fire  = frame_valid && !frame_stall;
    assign result_fire = result_valid_reg && !result_stall;
    assign end_hit     = frame_fire && is_end && armed_reg;
    assign ck          = (running_xor_reg == data_byte_1);

    assign payload[0] = data_byte_2;
    assign payload[1] = data_byte_3;
    assign payload[2] = data_byte_4;
    assign payload[3] = data_byte_5;
    assign payload[4] = data_byte_6;
    assign payload[5] = data_byte_7;

    ccr_count u_name_count (
        .frame_length (frame_length),
        .expected     (name_expected_reg),
        .have         (name_received_reg),
        .cap          (SUM_W'(NAME_MAX)),
        .chunk        (name_chunk)
    );

    ccr_count u_secret_count (
        .frame_length (frame_length),
        .expected     (secret_expected_reg),
        .have         (secret_received_reg),
        .cap          (SUM_W'(SECRET_MAX)),
        .chunk        (secret_chunk)
    );

    assign sel_chunk   = (action == ACT_SECRET) ? secret_chunk : name_chunk;
    assign lane_enable = armed_reg && is_chunk && sel_chunk.take;

    for (genvar i = 0; i < CHUNK_BYTES; i++)
    begin : g_lane
        ccr_lane u_lane (
            .data       (payload[i]),
            .lane_index (N_W'(i)),
            .n          (sel_chunk.n),
            .enable     (lane_enable),
            .masked     (lane_bytes[i])
        );
    end

    ccr_merge u_merge (
        .xor_in     (running_xor_reg),
        .lane_bytes (lane_bytes),
        .xor_out    (xor_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg           <= 1'b0;
            name_expected_reg   <= 8'd0;
            secret_expected_reg <= 8'd0;
            name_received_reg   <= '0;
            secret_received_reg <= '0;
            running_xor_reg     <= 8'd0;
        end
        else if (frame_fire)
        begin
            case (action)
                ACT_START:
                begin
                    name_expected_reg   <= data_byte_1;
                    secret_expected_reg <= data_byte_2;
                    name_received_reg   <= '0;
                    secret_received_reg <= '0;
                    running_xor_reg     <= 8'd0;
                    armed_reg           <= 1'b1;
                end
                ACT_NAME:
                begin
                    if (armed_reg && name_chunk.take)
                    begin
                        name_received_reg <= name_chunk.count;
                        running_xor_reg   <= xor_next;
                    end
                end
                ACT_SECRET:
                begin
                    if (armed_reg && secret_chunk.take)
                    begin
                        secret_received_reg <= secret_chunk.count;
                        running_xor_reg     <= xor_next;
                    end
                end
                ACT_END:
                begin
                    armed_reg <= 1'b0;
                end
                default:
                begin
                    armed_reg <= armed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (end_hit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_fire)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_hit)
        begin
            checksum_ok_reg  <= ck;
            accepted_reg     <= ck && ({2'b00, name_received_reg} == name_expected_reg)
                                   && ({2'b00, secret_received_reg} == secret_expected_reg);
            name_count_reg   <= name_received_reg;
            secret_count_reg <= secret_received_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign accepted     = accepted_reg;
    assign checksum_ok  = checksum_ok_reg;
    assign name_count   = name_count_reg;
    assign secret_count = secret_count_reg;

    `CCR_ASSERT_NEXT(a_end_gives_result, end_hit, result_valid_reg)
    `CCR_ASSERT_NEXT(a_end_disarms, frame_fire && is_end, !armed_reg)
    `CCR_ASSERT_SAME(a_name_in_store, 1'b1, {1'b0, name_received_reg} <= SUM_W'(NAME_MAX))
    `CCR_ASSERT_NEXT(a_held_result_stable, result_valid_reg && result_stall,
                     result_valid_reg && $stable(name_count_reg))

endmodule
